/* rtl/crc_keyed_decode_queue_core_macros.svh */
// assertion macros for the decode queue checker
`ifndef CRC_KEYED_DECODE_QUEUE_CORE_MACROS_SVH
`define CRC_KEYED_DECODE_QUEUE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while in reset
`define CKDQ_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ckdq check failed");

// next-cycle implication, clocked on clk, quiet while in reset
`define CKDQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ckdq check failed");

`endif

/* rtl/ckdq_pkg.sv */
// shared constants, codes and the command type of the decode queue
`default_nettype none

package ckdq_pkg;

  localparam int PEND_DEPTH = 16;
  localparam int DONE_DEPTH = 64;

  localparam int PA_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int PC_W = $clog2(PEND_DEPTH + 1);
  localparam int DA_W = (DONE_DEPTH > 1) ? $clog2(DONE_DEPTH) : 1;
  localparam int DC_W = $clog2(DONE_DEPTH + 1);
  localparam int QCMP_W = (PC_W > 8) ? PC_W : 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  // four bytes a pixel
  localparam int BPP_SHIFT = 2;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DELIV = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] OP_IDENT = 2'd0;
  localparam logic [1:0] OP_DELIV = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ident;
    logic        valid;
    logic [7:0]  qidx;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/ckdq_front.sv */
// front end: accepts beats, folds the crc and turns items into commands
`default_nettype none

module ckdq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic [31:0]        in_ident_in,
  input  logic signed [15:0] in_image_width,
  input  logic signed [15:0] in_image_height,
  input  logic [31:0]        in_byte_count,
  input  logic [7:0]         in_query_index,
  input  logic               q_full,
  output logic               q_push,
  output ckdq_pkg::cmd_t     q_cmd
);
  import ckdq_pkg::*;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  logic [31:0] crc_r, crc_nxt, crc_fold;
  logic        accept;
  logic [29:0] area;
  logic [31:0] need;
  logic        deliv_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign crc_fold = crc_byte(crc_r, in_data_byte);

  // both sides positive, so the low 15 bits carry the whole value
  assign area     = 30'(in_image_width[14:0]) * 30'(in_image_height[14:0]);
  assign need     = 32'(area) << BPP_SHIFT;
  assign deliv_ok = (in_image_width > 16'sd0) && (in_image_height > 16'sd0) &&
                    (in_byte_count >= need);

  always_comb begin
    crc_nxt = crc_r;
    q_push  = 1'b0;
    q_cmd.op    = OP_IDENT;
    q_cmd.ident = in_ident_in;
    q_cmd.valid = deliv_ok;
    q_cmd.qidx  = in_query_index;
    if (accept) begin
      unique case (in_kind)
        KIND_DATA: begin
          if (in_last_byte) begin
            crc_nxt     = CRC_ONES;
            q_push      = 1'b1;
            q_cmd.ident = crc_fold ^ CRC_ONES;
          end else begin
            crc_nxt = crc_fold;
          end
        end
        KIND_DELIV: begin
          q_push   = 1'b1;
          q_cmd.op = OP_DELIV;
        end
        KIND_QUERY: begin
          q_push   = 1'b1;
          q_cmd.op = OP_QUERY;
        end
        KIND_CLEAR: begin
          crc_nxt  = CRC_ONES;
          q_push   = 1'b1;
          q_cmd.op = OP_CLEAR;
        end
        default: crc_nxt = crc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_ONES;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ckdq_queue.sv */
// short command queue between the front end and the table engine
`default_nettype none

module ckdq_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ckdq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ckdq_pkg::cmd_t head,
  output logic           empty
);
  import ckdq_pkg::*;

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == QC_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QA_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QA_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ckdq_back.sv */
// table engine: finished set and pending list scans, compaction, result register
`default_nettype none

module ckdq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ckdq_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_ident,
  output logic           out_already_decoded,
  output logic           out_newly_queued,
  output logic           out_image_stored,
  output logic [4:0]     out_pending_total,
  output logic           out_overflow
);
  import ckdq_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FSCAN   = 3'd1;
  localparam logic [2:0] ST_PSCAN   = 3'd2;
  localparam logic [2:0] ST_COMPACT = 3'd3;
  localparam logic [2:0] ST_QWAIT   = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [31:0] pend_mem [PEND_DEPTH];
  logic [31:0] done_mem [DONE_DEPTH];

  logic [2:0]      state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [DC_W-1:0] fidx_r, fidx_nxt, done_used_r, done_used_nxt;
  logic [PC_W-1:0] pidx_r, pidx_nxt, widx_r, widx_nxt, pend_used_r, pend_used_nxt;
  logic            dval_r, dval_nxt;
  logic [31:0]     res_ident_r, res_ident_nxt;
  logic            res_already_r, res_already_nxt, res_queued_r, res_queued_nxt;
  logic            res_stored_r, res_stored_nxt, res_ovf_r, res_ovf_nxt;

  logic [31:0]     prd_r, frd_r;
  logic            pwe, fwe;
  logic [PA_W-1:0] pra, pwa;
  logic [DA_W-1:0] fra, fwa;
  logic [31:0]     pwd, fwd;

  logic            f_more, f_hit, p_more, p_hit, q_in_range, slot_free;

  logic            out_valid_r;
  logic [31:0]     out_ident_r;
  logic            out_already_r, out_queued_r, out_stored_r, out_ovf_r;
  logic [4:0]      out_total_r;

  assign f_more     = fidx_r < done_used_r;
  assign f_hit      = dval_r && (frd_r == cmd_r.ident);
  assign p_more     = pidx_r < pend_used_r;
  assign p_hit      = dval_r && (prd_r == cmd_r.ident);
  assign q_in_range = QCMP_W'(q_head.qidx) < QCMP_W'(pend_used_r);
  assign slot_free  = !out_valid_r || out_ready;

  assign fra = fidx_r[DA_W-1:0];
  // the query read is issued straight from the queue head
  assign pra = (state_r == ST_IDLE) ? q_head.qidx[PA_W-1:0] : pidx_r[PA_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    fidx_nxt        = fidx_r;
    pidx_nxt        = pidx_r;
    widx_nxt        = widx_r;
    dval_nxt        = 1'b0;
    done_used_nxt   = done_used_r;
    pend_used_nxt   = pend_used_r;
    res_ident_nxt   = res_ident_r;
    res_already_nxt = res_already_r;
    res_queued_nxt  = res_queued_r;
    res_stored_nxt  = res_stored_r;
    res_ovf_nxt     = res_ovf_r;
    q_pop           = 1'b0;
    pwe             = 1'b0;
    pwa             = pend_used_r[PA_W-1:0];
    pwd             = cmd_r.ident;
    fwe             = 1'b0;
    fwa             = done_used_r[DA_W-1:0];
    fwd             = cmd_r.ident;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop           = 1'b1;
          cmd_nxt         = q_head;
          res_ident_nxt   = q_head.ident;
          res_already_nxt = 1'b0;
          res_queued_nxt  = 1'b0;
          res_stored_nxt  = 1'b0;
          res_ovf_nxt     = 1'b0;
          fidx_nxt        = '0;
          pidx_nxt        = '0;
          widx_nxt        = '0;
          unique case (q_head.op)
            OP_IDENT: state_nxt = ST_FSCAN;
            OP_DELIV: state_nxt = q_head.valid ? ST_FSCAN : ST_COMPACT;
            OP_QUERY: begin
              res_ident_nxt = '0;
              state_nxt     = q_in_range ? ST_QWAIT : ST_EMIT;
            end
            OP_CLEAR: begin
              res_ident_nxt = '0;
              pend_used_nxt = '0;
              done_used_nxt = '0;
              state_nxt     = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_FSCAN: begin
        if (f_hit || (!dval_r && !f_more)) begin
          if (cmd_r.op == OP_IDENT) begin
            if (f_hit) begin
              res_already_nxt = 1'b1;
              state_nxt       = ST_EMIT;
            end else begin
              pidx_nxt  = '0;
              state_nxt = ST_PSCAN;
            end
          end else begin
            if (f_hit) begin
              res_stored_nxt = 1'b1;
            end else if (done_used_r < DC_W'(DONE_DEPTH)) begin
              fwe            = 1'b1;
              done_used_nxt  = done_used_r + DC_W'(1);
              res_stored_nxt = 1'b1;
            end else begin
              res_ovf_nxt = 1'b1;
            end
            pidx_nxt  = '0;
            widx_nxt  = '0;
            state_nxt = ST_COMPACT;
          end
        end else if (f_more) begin
          fidx_nxt = fidx_r + DC_W'(1);
          dval_nxt = 1'b1;
        end
      end

      ST_PSCAN: begin
        if (p_hit || (!dval_r && !p_more)) begin
          if (!p_hit) begin
            if (pend_used_r < PC_W'(PEND_DEPTH)) begin
              pwe            = 1'b1;
              pend_used_nxt  = pend_used_r + PC_W'(1);
              res_queued_nxt = 1'b1;
            end else begin
              res_ovf_nxt = 1'b1;
            end
          end
          state_nxt = ST_EMIT;
        end else if (p_more) begin
          pidx_nxt = pidx_r + PC_W'(1);
          dval_nxt = 1'b1;
        end
      end

      ST_COMPACT: begin
        // keeps every entry but the delivered one; write slot trails the read slot
        if (dval_r && !p_hit) begin
          pwe      = 1'b1;
          pwa      = widx_r[PA_W-1:0];
          pwd      = prd_r;
          widx_nxt = widx_r + PC_W'(1);
        end
        if (p_more) begin
          pidx_nxt = pidx_r + PC_W'(1);
          dval_nxt = 1'b1;
        end else if (!dval_r) begin
          pend_used_nxt = widx_r;
          state_nxt     = ST_EMIT;
        end
      end

      ST_QWAIT: begin
        res_ident_nxt = prd_r;
        state_nxt     = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pend_mem[pwa] <= pwd;
    end
    prd_r <= pend_mem[pra];
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      done_mem[fwa] <= fwd;
    end
    frd_r <= done_mem[fra];
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    fidx_r        <= fidx_nxt;
    pidx_r        <= pidx_nxt;
    widx_r        <= widx_nxt;
    res_ident_r   <= res_ident_nxt;
    res_already_r <= res_already_nxt;
    res_queued_r  <= res_queued_nxt;
    res_stored_r  <= res_stored_nxt;
    res_ovf_r     <= res_ovf_nxt;
    if ((state_r == ST_EMIT) && slot_free) begin
      out_ident_r   <= res_ident_r;
      out_already_r <= res_already_r;
      out_queued_r  <= res_queued_r;
      out_stored_r  <= res_stored_r;
      out_ovf_r     <= res_ovf_r;
      out_total_r   <= 5'(pend_used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dval_r      <= 1'b0;
      done_used_r <= '0;
      pend_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dval_r      <= dval_nxt;
      done_used_r <= done_used_nxt;
      pend_used_r <= pend_used_nxt;
      if ((state_r == ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ident           = out_ident_r;
  assign out_already_decoded = out_already_r;
  assign out_newly_queued    = out_queued_r;
  assign out_image_stored    = out_stored_r;
  assign out_pending_total   = out_total_r;
  assign out_overflow        = out_ovf_r;

endmodule

`default_nettype wire

/* rtl/crc_keyed_decode_queue_core.sv */
// Content-addressed image work queue keyed by the reflected CRC-32 of each image.
// Input channel (in_valid/in_ready): one beat per item; kind selects data byte,
// delivery, pending query or clear. Output channel (out_valid/out_ready): one
// result beat per item, except a data byte not marked last, which gives none.
// Data bytes are taken one per cycle while the command queue has room; the crc
// is folded in the same cycle. Last byte, delivery, query and clear each go to a
// four-entry command queue and are worked off by the table engine in order.
// Engine time per command grows with the finished-set and pending-list fill:
//   last byte and valid delivery walk the finished set, then the pending list,
//   with less work on a hit or an empty table; an invalid delivery walks only
//   the pending list; query and clear walk neither. Engine time is set by the
//   single read port of each table, walked one entry a cycle, and by the in-place
//   pending compaction.
// Reset (rst_n low, synchronous) empties both tables, restarts the crc and
// drops queued commands; table contents need no clearing pass.
// A stalled receiver holds the result in the output register; the engine then
// waits, the command queue fills and in_ready falls once four commands wait.
`default_nettype none

module crc_keyed_decode_queue_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic [31:0]        in_ident_in,
  input  logic signed [15:0] in_image_width,
  input  logic signed [15:0] in_image_height,
  input  logic [31:0]        in_byte_count,
  input  logic [7:0]         in_query_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_ident,
  output logic               out_already_decoded,
  output logic               out_newly_queued,
  output logic               out_image_stored,
  output logic [4:0]         out_pending_total,
  output logic               out_overflow
);
  import ckdq_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  ckdq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_ident_in     (in_ident_in),
    .in_image_width  (in_image_width),
    .in_image_height (in_image_height),
    .in_byte_count   (in_byte_count),
    .in_query_index  (in_query_index),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  ckdq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ckdq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ident           (out_ident),
    .out_already_decoded (out_already_decoded),
    .out_newly_queued    (out_newly_queued),
    .out_image_stored    (out_image_stored),
    .out_pending_total   (out_pending_total),
    .out_overflow        (out_overflow)
  );

endmodule

`default_nettype wire

/* rtl/ckdq_checker.sv */
// port-level checks on the decode queue, bound to the top level
`default_nettype none

`include "crc_keyed_decode_queue_core_macros.svh"

module ckdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        out_ident,
  input logic               out_already_decoded,
  input logic               out_newly_queued,
  input logic               out_image_stored,
  input logic [4:0]         out_pending_total,
  input logic               out_overflow
);
  import ckdq_pkg::*;

  // a stalled result beat stays and holds its payload
  `CKDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ident) && $stable(out_pending_total))

  // the pending count never passes the list depth
  `CKDQ_ASSERT_IMPL(a_total_max, out_valid, 9'(out_pending_total) <= 9'(PEND_DEPTH))

  // a lookup outcome is at most one of found, queued or dropped
  `CKDQ_ASSERT_IMPL(a_lookup_excl, out_valid, $countones({out_already_decoded, out_newly_queued, out_overflow}) <= 1)

  // a stored delivery carries no lookup flags
  `CKDQ_ASSERT_IMPL(a_store_clean, out_valid && out_image_stored, !out_overflow && !out_already_decoded && !out_newly_queued)

endmodule

bind crc_keyed_decode_queue_core ckdq_checker u_ckdq_checker (.*);

`default_nettype wire

/* bench/crc_keyed_decode_queue_core_tb.sv */
// self-checking bench for the crc keyed decode queue core: directed and random beats against a predictor
module crc_keyed_decode_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckdq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASE_ITEMS    = 230;
  localparam int SEEN_KEEP      = 48;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic [31:0]        ident_in;
    logic signed [15:0] image_width;
    logic signed [15:0] image_height;
    logic [31:0]        byte_count;
    logic [7:0]         query_index;
  } work_item_t;

  localparam int ITEM_W = $bits(work_item_t);

  typedef struct packed {
    logic [31:0] ident;
    logic        already_decoded;
    logic        newly_queued;
    logic        image_stored;
    logic [4:0]  pending_total;
    logic        overflow;
  } queue_result_t;

  // byte 0 of an image sits in bytes[7:0]
  typedef struct packed {
    logic [3:0]  len;
    logic [95:0] bytes;
  } image_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  work_item_t drv_item = '0;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_ident;
  logic        out_already_decoded;
  logic        out_newly_queued;
  logic        out_image_stored;
  logic [4:0]  out_pending_total;
  logic        out_overflow;

  // pending beats and the expected result beats
  work_item_t    stim_q[$];
  queue_result_t expect_q[$];
  logic [31:0]   seen_ids[$];
  image_t        seen_images[$];

  // predictor state
  logic [31:0] crc_acc = CRC_ONES;
  logic [31:0] pend_list[$];
  logic [31:0] done_list[$];

  int beats_in = 0;
  int beats_out = 0;
  int fail_count = 0;
  int ids_new = 0;
  int ids_known = 0;
  int stores = 0;
  int overflows = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  crc_keyed_decode_queue_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (drv_item.kind),
    .in_data_byte        (drv_item.data_byte),
    .in_last_byte        (drv_item.last_byte),
    .in_ident_in         (drv_item.ident_in),
    .in_image_width      (drv_item.image_width),
    .in_image_height     (drv_item.image_height),
    .in_byte_count       (drv_item.byte_count),
    .in_query_index      (drv_item.query_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ident           (out_ident),
    .out_already_decoded (out_already_decoded),
    .out_newly_queued    (out_newly_queued),
    .out_image_stored    (out_image_stored),
    .out_pending_total   (out_pending_total),
    .out_overflow        (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] crc_fold(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic bit id_listed(logic [31:0] ids[$], logic [31:0] id);
    foreach (ids[i]) if (ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // returns 0 when the beat gives no result (a data byte not marked last)
  function automatic bit predict_queue(input work_item_t it, output queue_result_t res);
    logic [31:0] kept[$];
    longint need;
    res = '0;
    case (it.kind)
      KIND_DATA: begin
        crc_acc = crc_fold(crc_acc, it.data_byte);
        if (!it.last_byte) return 1'b0;
        res.ident = crc_acc ^ CRC_ONES;
        crc_acc = CRC_ONES;
        if (id_listed(done_list, res.ident)) begin
          res.already_decoded = 1'b1;
        end else if (!id_listed(pend_list, res.ident)) begin
          if (pend_list.size() < PEND_DEPTH) begin
            pend_list = {pend_list, res.ident};
            res.newly_queued = 1'b1;
          end else begin
            res.overflow = 1'b1;
          end
        end
      end
      KIND_DELIV: begin
        res.ident = it.ident_in;
        if ($signed(it.image_width) > 0 && $signed(it.image_height) > 0) begin
          need = longint'($signed(it.image_width)) * longint'($signed(it.image_height)) * 4;
          if (longint'(it.byte_count) >= need) begin
            if (id_listed(done_list, it.ident_in)) begin
              res.image_stored = 1'b1;
            end else if (done_list.size() < DONE_DEPTH) begin
              done_list = {done_list, it.ident_in};
              res.image_stored = 1'b1;
            end else begin
              res.overflow = 1'b1;
            end
          end
        end
        // removal keeps the order of the rest
        foreach (pend_list[i]) if (pend_list[i] != it.ident_in) kept = {kept, pend_list[i]};
        pend_list = kept;
      end
      KIND_QUERY: begin
        if (it.query_index < pend_list.size()) res.ident = pend_list[it.query_index];
      end
      KIND_CLEAR: begin
        crc_acc = CRC_ONES;
        pend_list.delete();
        done_list.delete();
      end
    endcase
    res.pending_total = 5'(pend_list.size());
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // fields that the kind does not use carry random bits
  function automatic work_item_t noise_item(logic [1:0] kind);
    work_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.kind = kind;
    return it;
  endfunction

  function automatic image_t fresh_image(int max_len);
    image_t img;
    img.len = 4'($urandom_range(1, max_len));
    img.bytes = {$urandom, $urandom, $urandom};
    return img;
  endfunction

  function automatic void push_image(image_t img, bit interleave);
    work_item_t it;
    logic [31:0] crc;
    crc = CRC_ONES;
    for (int i = 0; i < img.len; i++) begin
      it = noise_item(KIND_DATA);
      it.data_byte = img.bytes[8*i +: 8];
      it.last_byte = (i == img.len - 1);
      crc = crc_fold(crc, it.data_byte);
      stim_q = {stim_q, it};
      // a query slipped in mid-image must not disturb the checksum
      if (interleave && !it.last_byte && $urandom_range(0, 9) == 0)
        stim_q = {stim_q, noise_item(KIND_QUERY)};
    end
    seen_ids = {seen_ids, crc ^ CRC_ONES};
    seen_images = {seen_images, img};
    if (seen_ids.size() > SEEN_KEEP) void'(seen_ids.pop_front());
    if (seen_images.size() > SEEN_KEEP) void'(seen_images.pop_front());
  endfunction

  function automatic void push_delivery(logic [31:0] id, logic [15:0] w, logic [15:0] h,
                                        logic [31:0] count);
    work_item_t it;
    it = noise_item(KIND_DELIV);
    it.ident_in = id;
    it.image_width = w;
    it.image_height = h;
    it.byte_count = count;
    stim_q = {stim_q, it};
  endfunction

  // modes: 0-4 well formed, 5 one byte short, 6 bad width, 7 bad height, else raw bits
  function automatic void push_random_delivery(logic [31:0] id, int mode);
    work_item_t it;
    bit big;
    int wv;
    int hv;
    longint need;
    big = ($urandom_range(0, 9) == 0);
    wv = big ? $urandom_range(1, 32767) : $urandom_range(1, 40);
    hv = big ? $urandom_range(1, 32767) : $urandom_range(1, 40);
    need = longint'(wv) * longint'(hv) * 4;
    it = noise_item(KIND_DELIV);
    case (mode)
      0, 1, 2, 3, 4, 5, 6, 7: begin
        it.image_width = 16'(wv);
        it.image_height = 16'(hv);
        it.byte_count = 32'(need);
      end
      default: ;
    endcase
    case (mode)
      2, 3, 4: it.byte_count = big ? 32'hFFFF_FFFF : 32'(need + $urandom_range(1, 4096));
      5: it.byte_count = 32'(need - 1);
      6: it.image_width = 16'(0 - $urandom_range(0, 32768));
      7: it.image_height = 16'(0 - $urandom_range(0, 32768));
      default: ;
    endcase
    push_delivery(id, it.image_width, it.image_height, it.byte_count);
  endfunction

  function automatic void push_query(logic [7:0] idx);
    work_item_t it;
    it = noise_item(KIND_QUERY);
    it.query_index = idx;
    stim_q = {stim_q, it};
  endfunction

  task automatic load_directed();
    image_t img;
    img.len = 4'd1;
    img.bytes = 96'h0;
    push_image(img, 1'b0);
    for (int b = 1; b < 16; b++) begin
      img.bytes = 96'(b);
      push_image(img, 1'b0);
    end
    // seventeenth image finds the pending list full
    img.len = 4'd2;
    img.bytes = {80'd0, 8'h80, 8'hFF};
    push_image(img, 1'b0);
    // already pending while full: no second copy and no overflow
    img.len = 4'd1;
    img.bytes = 96'h1;
    push_image(img, 1'b0);
    push_delivery(seen_ids[0], 16'sd1, 16'sd1, 32'd4);
    img.bytes = 96'h0;
    push_image(img, 1'b0);
    push_delivery(seen_ids[0], 16'sd2, 16'sd2, 32'd16);
    push_delivery(seen_ids[1], 16'sd2, 16'sd3, 32'd23);
    push_delivery(seen_ids[2], 16'h8000, 16'sd32767, 32'hFFFF_FFFF);
    // largest valid image, id never made it onto the pending list
    push_delivery(seen_ids[16], 16'sd32767, 16'sd32767, 32'hFFFF_FFFF);
    push_query(8'd255);
    stim_q = {stim_q, noise_item(KIND_CLEAR)};
  endtask

  task automatic load_random(int n);
    int start;
    int r;
    logic [31:0] id;
    start = stim_q.size();
    while (stim_q.size() - start < n) begin
      r = $urandom_range(0, 999);
      if (r < 3) begin
        stim_q = {stim_q, noise_item(KIND_CLEAR)};
      end else if (r < 10) begin
        // run of short images to fill the pending list
        repeat (18) push_image(fresh_image(3), 1'b1);
      end else if (r < 20) begin
        // run of valid deliveries to fill the finished set
        repeat (24) push_random_delivery($urandom, $urandom_range(0, 4));
      end else if (r < 420) begin
        if (seen_images.size() > 0 && $urandom_range(0, 4) == 0)
          push_image(seen_images[$urandom_range(0, seen_images.size() - 1)], 1'b1);
        else
          push_image(fresh_image(($urandom_range(0, 9) == 0) ? 12 : 5), 1'b1);
      end else if (r < 720) begin
        if (seen_ids.size() > 0 && $urandom_range(0, 3) != 0)
          id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
        else
          id = $urandom;
        push_random_delivery(id, $urandom_range(0, 9));
      end else begin
        push_query(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 17)));
      end
    end
  endtask

  task automatic wait_drained();
    while (!(stim_q.size() == 0 && !in_valid && expect_q.size() == 0)) @(posedge clk);
    @(posedge clk);
  endtask

  // driver: predicts each accepted beat, then loads the next one
  always @(posedge clk) begin
    queue_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        beats_in++;
        if (predict_queue(drv_item, res)) begin
          expect_q = {expect_q, res};
          ids_new += res.newly_queued;
          ids_known += res.already_decoded;
          stores += res.image_stored;
          overflows += res.overflow;
        end
      end
      if (!in_valid || in_ready) begin
        if (stim_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_item <= stim_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result beat with the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (expect_q.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, got ident %0h",
                   $time, out_ident);
          fail_count++;
        end else begin
          want = expect_q.pop_front();
          check_field("ident", want.ident, out_ident);
          check_field("already_decoded", 32'(want.already_decoded), 32'(out_already_decoded));
          check_field("newly_queued", 32'(want.newly_queued), 32'(out_newly_queued));
          check_field("image_stored", 32'(want.image_stored), 32'(out_image_stored));
          check_field("pending_total", 32'(want.pending_total), 32'(out_pending_total));
          check_field("overflow", 32'(want.overflow), 32'(out_overflow));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** crc_keyed_decode_queue_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    load_directed();
    load_random(PHASE_ITEMS);
    wait_drained();
    idle_pct = 47;
    stall_pct = 0;
    load_random(PHASE_ITEMS);
    wait_drained();
    idle_pct = 0;
    stall_pct = 47;
    load_random(PHASE_ITEMS);
    wait_drained();
    idle_pct = 34;
    stall_pct = 34;
    load_random(PHASE_ITEMS);
    wait_drained();
    // late extra results would still be caught here
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d input beats and %0d result beats over four idling phases",
             beats_in, beats_out);
    $display("ids queued %0d, already finished %0d, images stored %0d, overflows %0d",
             ids_new, ids_known, stores, overflows);
    if (fail_count == 0 && expect_q.size() == 0) begin
      $display("** crc_keyed_decode_queue_core: PASSED **");
    end else begin
      $display("** crc_keyed_decode_queue_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ckdq_pkg.sv
rtl/ckdq_front.sv
rtl/ckdq_queue.sv
rtl/ckdq_back.sv
rtl/crc_keyed_decode_queue_core.sv
rtl/ckdq_checker.sv
bench/crc_keyed_decode_queue_core_tb.sv
